// File: src/ist_pkg.sv
// Shared types and constants of the interval set table.
// Used by ist_cmp and interval_set_table_top; depends on nothing else.
package ist_pkg;

    localparam int DATA_W         = 64;
    localparam int DEF_MAX_RANGES = 32;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_READ   = 2'd3
    } t_req;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_BAD_RANGE = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LEFT,
        ST_RIGHT,
        ST_KEEP,
        ST_MLO,
        ST_MHI,
        ST_CUTLO,
        ST_CUTHI,
        ST_QLO,
        ST_QHI,
        ST_FINAL,
        ST_COMMIT,
        ST_READ,
        ST_RDWAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic              cin;
    } t_cmp_req;

endpackage

// File: src/ist_cmp.sv
// Shared signed compare unit: reports whether x plus a carry-in lies below y.
// Depends on ist_pkg for the request struct.
module ist_cmp (
    input  ist_pkg::t_cmp_req i_req,
    output logic              o_lt
);
    import ist_pkg::*;

    logic [DATA_W:0] sum;
    logic [DATA_W:0] rhs;

    assign sum  = {i_req.x[DATA_W-1], i_req.x} + (DATA_W + 1)'(i_req.cin);
    assign rhs  = {i_req.y[DATA_W-1], i_req.y};
    assign o_lt = $signed(sum) < $signed(rhs);

endmodule

// File: src/interval_set_table_top.sv
// Top level of the interval set table: sequencer, two-bank range memory, output register.
// Depends on ist_pkg and ist_cmp.
//
//   channel   direction   handshake            payload
//   request   in          i_valid / o_stall    i_req_type, i_range_lo, i_range_hi, i_entry_index
//   result    out         o_valid / i_stall    o_included, o_status, o_entry_lo, o_entry_hi,
//                                              o_entry_valid, o_range_count
//
// A read addresses the entry in ST_READ and, for an index in range, latches it in ST_RDWAIT.
// Add, remove and query scan the stored ranges one entry at a time through the single
// compare unit and the single memory read port: a fetch and two bound compares per entry,
// then a keep, merge or cut step for add and remove, which end with a final write and a commit.
// Reset clears the state, range count, bank select and output valid; the memory is not cleared.
// A finished word waits in the output register, and the next request is taken meanwhile.
module interval_set_table_top #(
    parameter int MAX_RANGES = ist_pkg::DEF_MAX_RANGES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_req_type,
    input  logic [ist_pkg::DATA_W-1:0]  i_range_lo,
    input  logic [ist_pkg::DATA_W-1:0]  i_range_hi,
    input  logic [4:0]                  i_entry_index,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_included,
    output logic [1:0]                  o_status,
    output logic [ist_pkg::DATA_W-1:0]  o_entry_lo,
    output logic [ist_pkg::DATA_W-1:0]  o_entry_hi,
    output logic                        o_entry_valid,
    output logic [5:0]                  o_range_count
);
    import ist_pkg::*;

    localparam int AW    = $clog2(MAX_RANGES);
    localparam int CW    = $clog2(MAX_RANGES + 2);
    localparam int DEPTH = 2 ** (AW + 1);

    t_state r_state, n_state;

    logic [2*DATA_W-1:0] r_mem [0:DEPTH-1];
    logic [2*DATA_W-1:0] r_rd_data;

    t_req              r_req;
    logic [DATA_W-1:0] r_lo, r_hi, r_lo_m1, r_hi_p1;
    logic [4:0]        r_idx;
    logic [CW-1:0]     r_i, r_n, r_count;
    logic              r_placed, r_bank;

    logic              r_res_included, r_res_valid;
    logic [1:0]        r_res_status;
    logic [DATA_W-1:0] r_res_lo, r_res_hi;

    logic              r_out_valid, r_out_included, r_out_entry_valid;
    logic [1:0]        r_out_status;
    logic [DATA_W-1:0] r_out_lo, r_out_hi;
    logic [5:0]        r_out_count;

    logic              acc, out_load, cmp_lt, scan_end, rd_ok, over;
    logic [CW-1:0]     i_next;
    logic [DATA_W-1:0] ent_lo, ent_hi;
    t_cmp_req          cmp_req;

    logic              wr_req, wr_fire, set_placed, upd_lo, upd_hi;
    logic [DATA_W-1:0] wr_lo, wr_hi;
    logic [AW:0]       rd_addr, wr_addr;

    ist_cmp u_cmp (
        .i_req (cmp_req),
        .o_lt  (cmp_lt)
    );

    assign acc      = i_valid && (r_state == ST_IDLE);
    assign o_stall  = (r_state != ST_IDLE);
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || !i_stall);
    assign ent_lo   = r_rd_data[DATA_W-1:0];
    assign ent_hi   = r_rd_data[2*DATA_W-1:DATA_W];
    assign i_next   = r_i + CW'(1);
    assign scan_end = (i_next == r_count);
    assign rd_ok    = (32'(r_idx) < 32'(r_count)) && (32'(r_idx) < 32'(MAX_RANGES));
    assign over     = (r_n > CW'(MAX_RANGES));
    assign wr_fire  = wr_req && (r_n < CW'(MAX_RANGES));
    assign wr_addr  = {~r_bank, r_n[AW-1:0]};

    always_comb begin
        t_state scan_tgt;
        scan_tgt = ST_FETCH;
        if (scan_end) begin
            scan_tgt = (r_req == REQ_QUERY) ? ST_DONE : ST_FINAL;
        end
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (t_req'(i_req_type) == REQ_READ) begin
                        n_state = ST_READ;
                    end else if (cmp_lt) begin
                        n_state = ST_DONE;
                    end else if (r_count == '0) begin
                        n_state = (t_req'(i_req_type) == REQ_QUERY) ? ST_DONE : ST_FINAL;
                    end else begin
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_FETCH:  n_state = (r_req == REQ_QUERY) ? ST_QLO : ST_LEFT;
            ST_LEFT:   n_state = cmp_lt ? scan_tgt : ST_RIGHT;
            ST_RIGHT: begin
                if (cmp_lt) begin
                    n_state = (r_req == REQ_ADD && !r_placed) ? ST_KEEP : scan_tgt;
                end else begin
                    n_state = (r_req == REQ_ADD) ? ST_MLO : ST_CUTLO;
                end
            end
            ST_KEEP:   n_state = scan_tgt;
            ST_MLO:    n_state = ST_MHI;
            ST_MHI:    n_state = scan_tgt;
            ST_CUTLO:  n_state = ST_CUTHI;
            ST_CUTHI:  n_state = scan_tgt;
            ST_QLO:    n_state = cmp_lt ? scan_tgt : ST_QHI;
            ST_QHI:    n_state = cmp_lt ? scan_tgt : ST_DONE;
            ST_FINAL:  n_state = ST_COMMIT;
            ST_COMMIT: n_state = ST_DONE;
            ST_READ:   n_state = rd_ok ? ST_RDWAIT : ST_DONE;
            ST_RDWAIT: n_state = ST_DONE;
            ST_DONE:   n_state = out_load ? ST_IDLE : ST_DONE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        cmp_req    = '{x: r_hi, y: r_lo, cin: 1'b0};
        wr_req     = 1'b0;
        wr_lo      = ent_lo;
        wr_hi      = ent_hi;
        set_placed = 1'b0;
        upd_lo     = 1'b0;
        upd_hi     = 1'b0;
        rd_addr    = {r_bank, r_i[AW-1:0]};
        unique case (r_state)
            ST_IDLE: begin
                cmp_req = '{x: i_range_hi, y: i_range_lo, cin: 1'b0};
            end
            ST_LEFT: begin
                cmp_req = '{x: ent_hi, y: r_lo, cin: (r_req == REQ_ADD)};
                wr_req  = cmp_lt;
            end
            ST_RIGHT: begin
                cmp_req = '{x: r_hi, y: ent_lo, cin: (r_req == REQ_ADD)};
                wr_req  = cmp_lt;
                if (r_req == REQ_ADD && !r_placed) begin
                    wr_lo      = r_lo;
                    wr_hi      = r_hi;
                    set_placed = cmp_lt;
                end
            end
            ST_KEEP: begin
                wr_req = 1'b1;
            end
            ST_MLO: begin
                cmp_req = '{x: ent_lo, y: r_lo, cin: 1'b0};
                upd_lo  = cmp_lt;
            end
            ST_MHI: begin
                cmp_req = '{x: r_hi, y: ent_hi, cin: 1'b0};
                upd_hi  = cmp_lt;
            end
            ST_CUTLO: begin
                cmp_req = '{x: ent_lo, y: r_lo, cin: 1'b0};
                wr_req  = cmp_lt;
                wr_hi   = r_lo_m1;
            end
            ST_CUTHI: begin
                cmp_req = '{x: r_hi, y: ent_hi, cin: 1'b0};
                wr_req  = cmp_lt;
                wr_lo   = r_hi_p1;
            end
            ST_QLO: begin
                cmp_req = '{x: r_lo, y: ent_lo, cin: 1'b0};
            end
            ST_QHI: begin
                cmp_req = '{x: ent_hi, y: r_hi, cin: 1'b0};
            end
            ST_FINAL: begin
                wr_req = (r_req == REQ_ADD) && !r_placed;
                wr_lo  = r_lo;
                wr_hi  = r_hi;
            end
            ST_READ: begin
                rd_addr = {r_bank, AW'(r_idx)};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[wr_addr] <= {wr_hi, wr_lo};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_COMMIT && !over) begin
                r_count <= r_n;
                r_bank  <= ~r_bank;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_req          <= t_req'(i_req_type);
            r_lo           <= i_range_lo;
            r_hi           <= i_range_hi;
            r_lo_m1        <= i_range_lo - DATA_W'(1);
            r_hi_p1        <= i_range_hi + DATA_W'(1);
            r_idx          <= i_entry_index;
            r_i            <= '0;
            r_n            <= '0;
            r_placed       <= 1'b0;
            r_res_included <= 1'b0;
            r_res_valid    <= 1'b0;
            r_res_lo       <= '0;
            r_res_hi       <= '0;
            r_res_status   <= (t_req'(i_req_type) != REQ_READ && cmp_lt)
                              ? STS_BAD_RANGE : STS_OK;
        end else begin
            if (upd_lo) begin
                r_lo <= ent_lo;
            end
            if (upd_hi) begin
                r_hi <= ent_hi;
            end
            if (wr_req) begin
                r_n <= r_n + CW'(1);
            end
            if (set_placed) begin
                r_placed <= 1'b1;
            end
            if (r_state != ST_IDLE && n_state == ST_FETCH) begin
                r_i <= i_next;
            end
            if (r_state == ST_QHI && !cmp_lt) begin
                r_res_included <= 1'b1;
            end
            if (r_state == ST_COMMIT && over) begin
                r_res_status <= STS_FULL;
            end
            if (r_state == ST_RDWAIT) begin
                r_res_lo    <= ent_lo;
                r_res_hi    <= ent_hi;
                r_res_valid <= 1'b1;
            end
        end
        if (out_load) begin
            r_out_included    <= r_res_included;
            r_out_status      <= r_res_status;
            r_out_lo          <= r_res_lo;
            r_out_hi          <= r_res_hi;
            r_out_entry_valid <= r_res_valid;
            r_out_count       <= 6'(r_count);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_included    = r_out_included;
    assign o_status      = r_out_status;
    assign o_entry_lo    = r_out_lo;
    assign o_entry_hi    = r_out_hi;
    assign o_entry_valid = r_out_entry_valid;
    assign o_range_count = r_out_count;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RANGES))
        else $error("range count exceeds table capacity");

    a_count_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |-> $past(r_state == ST_COMMIT))
        else $error("range count changed outside commit");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> $past(r_state == ST_DONE))
        else $error("result word appeared without a finished request");
`endif

endmodule
